// ===== hdl/prs_pkg.sv =====
// Shared word types and constants of the platform run supervisor.
package prs_pkg;

  // Width of the configuration register index and data.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 2;

  // Fast blink: the ready LED is lit while (ms_count mod 200) > 100.
  // The modulus is split as 8 * 25; the divide by 25 of the upper 29 bits is
  // a multiply by a rounded-up reciprocal, exact for all 29-bit dividends.
  localparam int unsigned BlinkDivW    = 29;
  localparam int unsigned RecipShift   = 33;
  localparam logic [BlinkDivW-1:0] RecipMul = 29'd343597384;
  localparam logic [7:0] BlinkOnAbove  = 8'd100;

  typedef struct packed {
    logic [2:0]  func;
    logic        set_value;
    logic        button_enable_system;
    logic        button_enable_control;
    logic        button_stop;
    logic        external_stop_n;
    logic [31:0] ms_count;
    logic [31:0] sec_count;
  } prs_in_t;

  typedef struct packed {
    logic [1:0] state_code;
    logic       power_enable;
    logic       ready_led;
    logic       running_led;
    logic       error_led;
    logic       user_led;
    logic       system_enabled;
    logic       control_enabled;
    logic       handshake_fault;
  } prs_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } prs_cfg_t;

endpackage

// ===== hdl/prs_if.sv =====
// Valid/ready channel interfaces for input, result and configuration words.
interface prs_in_if;
  import prs_pkg::*;
  logic    valid;
  logic    ready;
  prs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prs_out_if;
  import prs_pkg::*;
  logic     valid;
  logic     ready;
  prs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface prs_cfg_if;
  import prs_pkg::*;
  logic     valid;
  logic     ready;
  prs_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/platform_run_supervisor.sv =====
// Top level of the platform run supervisor: four-state run/control/error machine.
//
//   Channel | Dir | Word                                   | Accepted when
//   --------+-----+----------------------------------------+---------------------
//   in_i    | in  | func, set value, buttons, uptimes      | in_i.valid & ready
//   res_o   | out | state code, power, LEDs, flags, fault  | res_o.valid & ready
//   cfg_i   | in  | register index, write data             | cfg_i.valid & ready
//
// Each input word is captured in an input register; when the result register can
// take it, the word is evaluated (a flag write, or for tick and error words the
// entry action, during rules and button sampling) and written into the state
// and result registers at once. One word per cycle is sustained while res_o is ready.
// The input register advances whenever the result register is empty or being
// drained, so a stalled result holds at most one word behind it.
// Reset brings the machine to idle with its entry action still pending, all
// flags and LEDs off, button mode 3 and the external stop disabled.
// Configuration writes are always accepted and take effect on the next cycle.
module platform_run_supervisor (
  input  logic            clk_i,
  input  logic            rst_ni,
  prs_in_if.sink          in_i,
  prs_out_if.source       res_o,
  prs_cfg_if.sink         cfg_i
);
  import prs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_CONTROL = 2'd2,
    ST_ERROR   = 2'd3
  } mode_state_e;

  typedef enum logic [2:0] {
    FUNC_STEP      = 3'd0,
    FUNC_SET_ERROR = 3'd1,
    FUNC_SET_USER  = 3'd2,
    FUNC_SET_SYS   = 3'd3,
    FUNC_SET_CTRL  = 3'd4,
    FUNC_SET_STOP  = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    BTN_NONE      = 2'd0,
    BTN_CLEAR     = 2'd1,
    BTN_STOP_LOW  = 2'd2,
    BTN_STOP_HIGH = 2'd3
  } button_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUTTON_MODE = 1'b0,
    CFG_EXT_STOP_EN = 1'b1
  } cfg_index_e;

  // LED bit positions.
  localparam int unsigned LedReady   = 0;
  localparam int unsigned LedRunning = 1;
  localparam int unsigned LedError   = 2;
  localparam int unsigned LedUser    = 3;

  // Configuration registers.
  button_mode_e button_mode_q;
  logic         ext_stop_en_q;

  // Pipeline registers.
  logic     in_valid_q;
  prs_in_t  in_q;
  logic     out_valid_q;
  prs_out_t out_q;

  // Supervisor state.
  mode_state_e state_q, state_d;
  logic        pend_q, pend_d;
  logic        done_q, done_d;
  logic        sys_q, sys_d;
  logic        ctrl_q, ctrl_d;
  logic        stop_q, stop_d;
  logic        flt_q, flt_d;
  logic [3:0]  led_q, led_d;
  logic        pwr_q, pwr_d;
  logic        hs_q, hs_d;

  logic advance;
  logic in_ready;
  logic fire;

  assign advance  = !out_valid_q || res_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign fire     = in_valid_q && advance;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  // Fast blink phase: remainder of ms_count by 200 compared against 100.
  logic [BlinkDivW-1:0]   ms_hi;
  logic [2*BlinkDivW-1:0] recip_prod;
  logic [BlinkDivW-1:0]   quot;
  logic [BlinkDivW-1:0]   quot_x25;
  logic [BlinkDivW-1:0]   rem25;
  logic [7:0]             rem200;
  logic                   fast_blink;

  assign ms_hi      = in_q.ms_count[31:3];
  assign recip_prod = ms_hi * RecipMul;
  assign quot       = BlinkDivW'(recip_prod >> RecipShift);
  assign quot_x25   = (quot << 4) + (quot << 3) + quot;
  assign rem25      = ms_hi - quot_x25;
  assign rem200     = {rem25[4:0], in_q.ms_count[2:0]};
  assign fast_blink = rem200 > BlinkOnAbove;

  // Next-state evaluation of one word.
  logic        do_step;
  logic        go;
  mode_state_e go_state;
  logic        err_s;
  logic        stp_s;

  always_comb begin
    state_d  = state_q;
    pend_d   = pend_q;
    done_d   = done_q;
    sys_d    = sys_q;
    ctrl_d   = ctrl_q;
    stop_d   = stop_q;
    flt_d    = flt_q;
    led_d    = led_q;
    pwr_d    = pwr_q;
    hs_d     = hs_q;
    do_step  = 1'b0;
    go       = 1'b0;
    go_state = ST_IDLE;
    err_s    = 1'b0;
    stp_s    = 1'b0;

    unique case (in_q.func)
      FUNC_STEP: begin
        do_step = 1'b1;
      end
      FUNC_SET_ERROR: begin
        if (in_q.set_value && state_q != ST_ERROR) begin
          // A switch before the last entry action ran latches the fault.
          if (!done_d) begin
            hs_d = 1'b1;
          end
          done_d  = 1'b0;
          pend_d  = 1'b1;
          state_d = ST_ERROR;
        end
        flt_d   = in_q.set_value;
        do_step = 1'b1;
      end
      FUNC_SET_USER: led_d[LedUser] = in_q.set_value;
      FUNC_SET_SYS:  sys_d  = in_q.set_value;
      FUNC_SET_CTRL: ctrl_d = in_q.set_value;
      FUNC_SET_STOP: stop_d = in_q.set_value;
      default: ;
    endcase

    if (do_step) begin
      // Entry action, once after each switch.
      if (pend_d) begin
        unique case (state_d)
          ST_IDLE: begin
            pwr_d            = 1'b0;
            ctrl_d           = 1'b0;
            sys_d            = 1'b0;
            stop_d           = 1'b0;
            flt_d            = 1'b0;
            led_d[LedError]   = 1'b0;
            led_d[LedRunning] = 1'b0;
          end
          ST_RUNNING: begin
            led_d[LedError]   = 1'b0;
            led_d[LedRunning] = 1'b0;
            pwr_d             = 1'b1;
          end
          ST_CONTROL: begin
            led_d[LedError]   = 1'b0;
            led_d[LedRunning] = 1'b1;
          end
          ST_ERROR: begin
            pwr_d = 1'b0;
            led_d = 4'b0000;
            led_d[LedError] = 1'b1;
          end
        endcase
        done_d = 1'b1;
        pend_d = 1'b0;
      end

      // During rules: ready LED blink and at most one transition.
      err_s = flt_d;
      stp_s = stop_d;
      unique case (state_d)
        ST_IDLE: begin
          led_d[LedReady] = in_q.sec_count[0];
          if (sys_d && !err_s && !stp_s) begin
            go       = 1'b1;
            go_state = ST_RUNNING;
          end else if (err_s) begin
            go       = 1'b1;
            go_state = ST_ERROR;
          end
        end
        ST_RUNNING, ST_CONTROL: begin
          led_d[LedReady] = fast_blink;
          if (err_s) begin
            go       = 1'b1;
            go_state = ST_ERROR;
          end else if (stp_s) begin
            go       = 1'b1;
            go_state = ST_IDLE;
          end else if (state_d == ST_RUNNING && ctrl_d) begin
            go       = 1'b1;
            go_state = ST_CONTROL;
          end
        end
        ST_ERROR: begin
          if (stp_s) begin
            go       = 1'b1;
            go_state = ST_IDLE;
          end
        end
      endcase
      if (go) begin
        if (!done_d) begin
          hs_d = 1'b1;
        end
        done_d  = 1'b0;
        pend_d  = 1'b1;
        state_d = go_state;
      end

      // Button sampling.
      unique case (button_mode_q)
        BTN_NONE: ;
        BTN_CLEAR: begin
          sys_d  = 1'b0;
          ctrl_d = 1'b0;
          stop_d = 1'b0;
        end
        BTN_STOP_LOW, BTN_STOP_HIGH: begin
          sys_d  = in_q.button_enable_system;
          ctrl_d = in_q.button_enable_control;
          stop_d = (button_mode_q == BTN_STOP_HIGH) ? in_q.button_stop : !in_q.button_stop;
          if (ext_stop_en_q && !in_q.external_stop_n) begin
            stop_d = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      button_mode_q <= BTN_STOP_HIGH;
      ext_stop_en_q <= 1'b0;
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      state_q       <= ST_IDLE;
      pend_q        <= 1'b1;
      done_q        <= 1'b1;
      sys_q         <= 1'b0;
      ctrl_q        <= 1'b0;
      stop_q        <= 1'b0;
      flt_q         <= 1'b0;
      led_q         <= 4'b0000;
      pwr_q         <= 1'b0;
      hs_q          <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_index_e'(cfg_i.data.index))
          CFG_BUTTON_MODE: button_mode_q <= button_mode_e'(cfg_i.data.data);
          CFG_EXT_STOP_EN: ext_stop_en_q <= cfg_i.data.data[0];
        endcase
      end
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
        pend_q  <= pend_d;
        done_q  <= done_d;
        sys_q   <= sys_d;
        ctrl_q  <= ctrl_d;
        stop_q  <= stop_d;
        flt_q   <= flt_d;
        led_q   <= led_d;
        pwr_q   <= pwr_d;
        hs_q    <= hs_d;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_q <= in_i.data;
    end
    if (fire) begin
      out_q.state_code      <= state_d;
      out_q.power_enable    <= pwr_d;
      out_q.ready_led       <= led_d[LedReady];
      out_q.running_led     <= led_d[LedRunning];
      out_q.error_led       <= led_d[LedError];
      out_q.user_led        <= led_d[LedUser];
      out_q.system_enabled  <= sys_d;
      out_q.control_enabled <= ctrl_d;
      out_q.handshake_fault <= hs_d;
    end
  end

endmodule

// ===== sim/platform_run_supervisor_tb.sv =====
// Self-checking testbench for the platform run supervisor: random and directed words, scoreboard.
module platform_run_supervisor_tb;
  import prs_pkg::*;

  // Function codes carried in the func field of an input word. The two top codes are unused
  // by the block and must leave every state bit alone.
  typedef enum logic [2:0] {
    FuncStep       = 3'd0,
    FuncSetError   = 3'd1,
    FuncSetUserLed = 3'd2,
    FuncSetSysEn   = 3'd3,
    FuncSetCtrlEn  = 3'd4,
    FuncSetStop    = 3'd5,
    FuncSpare6     = 3'd6,
    FuncSpare7     = 3'd7
  } func_e;

  // Supervisor states as they show up in the state_code field of a result word.
  typedef enum logic [1:0] {
    StIdle    = 2'd0,
    StRunning = 2'd1,
    StControl = 2'd2,
    StError   = 2'd3
  } run_state_e;

  // Button sampling modes held in the button mode register.
  typedef enum logic [1:0] {
    ModeNoPoll    = 2'd0,
    ModeForceZero = 2'd1,
    ModeStopLow   = 2'd2,
    ModeStopHigh  = 2'd3
  } btn_mode_e;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegButtonMode = 1'b0;
  localparam logic [CfgIdxW-1:0] RegExtStopEn  = 1'b1;

  // Positions of the four LEDs inside the LED vector.
  localparam int unsigned LedReady   = 0;
  localparam int unsigned LedRunning = 1;
  localparam int unsigned LedError   = 2;
  localparam int unsigned LedUser    = 3;

  // Fast blink of the ready LED in running and control: lit when (ms mod 200) > 100.
  localparam logic [31:0] BlinkPeriodMs  = 32'd200;
  localparam logic [31:0] BlinkOnAboveMs = 32'd100;

  // The block answers once a word has passed its input and result registers, so SettleCycles
  // more cycles after the last result catch anything it should not have produced.
  localparam int unsigned SettleCycles = 4;
  // Length of the deliberate result stall that makes the block back up into its input.
  localparam int unsigned LongHold     = 150;
  // Cycles without any transfer on any channel before the run is declared hung. The longest
  // legal quiet stretch is the long result stall plus a long sender gap.
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned PhaseCount   = 10;
  localparam int unsigned PhaseWords   = 90;
  localparam int unsigned BurstWords   = 30;

  // Scoreboard: keeps its own copy of the supervisor state and configuration, predicts the
  // result word of each accepted input word and checks the result words in order.
  class supervisor_scoreboard;
    btn_mode_e  btn_mode;
    bit         ext_stop_en;
    run_state_e cur_state;
    bit         entry_pending;
    bit         entry_done;
    bit         sys_en;
    bit         ctrl_en;
    bit         stop_req;
    bit         fault_req;
    bit [3:0]   leds;
    bit         power_on;
    bit         hs_fault;
    prs_out_t   pending_outputs[$];
    int         results_seen;
    int         mismatches;

    function new();
      btn_mode      = ModeStopHigh;
      ext_stop_en   = 1'b0;
      cur_state     = StIdle;
      entry_pending = 1'b1;
      entry_done    = 1'b1;
      sys_en        = 1'b0;
      ctrl_en       = 1'b0;
      stop_req      = 1'b0;
      fault_req     = 1'b0;
      leds          = '0;
      power_on      = 1'b0;
      hs_fault      = 1'b0;
      results_seen  = 0;
      mismatches    = 0;
    endfunction

    function void write_reg(prs_cfg_t c);
      case (c.index)
        RegButtonMode: btn_mode = btn_mode_e'(c.data);
        RegExtStopEn:  ext_stop_en = c.data[0];
        default: ;
      endcase
    endfunction

    // A switch taken before the previous state's entry action has run latches the fault.
    function void switch_to(run_state_e s);
      if (!entry_done) hs_fault = 1'b1;
      entry_done    = 1'b0;
      entry_pending = 1'b1;
      cur_state     = s;
    endfunction

    function void run_entry();
      if (!entry_pending) return;
      case (cur_state)
        StIdle: begin
          power_on         = 1'b0;
          sys_en           = 1'b0;
          ctrl_en          = 1'b0;
          stop_req         = 1'b0;
          fault_req        = 1'b0;
          leds[LedError]   = 1'b0;
          leds[LedRunning] = 1'b0;
        end
        StRunning: begin
          leds[LedError]   = 1'b0;
          leds[LedRunning] = 1'b0;
          power_on         = 1'b1;
        end
        StControl: begin
          leds[LedError]   = 1'b0;
          leds[LedRunning] = 1'b1;
        end
        default: begin
          power_on       = 1'b0;
          leds           = '0;
          leds[LedError] = 1'b1;
        end
      endcase
      entry_done    = 1'b1;
      entry_pending = 1'b0;
    endfunction

    // During rules: blink the ready LED and take at most one transition, judged on the
    // flags as they stood when the rules started.
    function void run_during(logic [31:0] ms, logic [31:0] sec);
      bit err;
      bit stp;
      err = fault_req;
      stp = stop_req;
      case (cur_state)
        StIdle: begin
          leds[LedReady] = sec[0];
          if (sys_en && !err && !stp) switch_to(StRunning);
          else if (err) switch_to(StError);
        end
        StRunning, StControl: begin
          leds[LedReady] = (ms % BlinkPeriodMs) > BlinkOnAboveMs;
          if (err) switch_to(StError);
          else if (stp) switch_to(StIdle);
          else if (cur_state == StRunning && ctrl_en) switch_to(StControl);
        end
        default: begin
          if (stp) switch_to(StIdle);
        end
      endcase
    endfunction

    function void sample_buttons(prs_in_t w);
      if (btn_mode == ModeForceZero) begin
        sys_en   = 1'b0;
        ctrl_en  = 1'b0;
        stop_req = 1'b0;
      end else if (btn_mode == ModeStopLow || btn_mode == ModeStopHigh) begin
        sys_en   = w.button_enable_system;
        ctrl_en  = w.button_enable_control;
        stop_req = (btn_mode == ModeStopHigh) ? w.button_stop : !w.button_stop;
        if (ext_stop_en && !w.external_stop_n) stop_req = 1'b1;
      end
    endfunction

    function void run_tick(prs_in_t w);
      run_entry();
      run_during(w.ms_count, w.sec_count);
      sample_buttons(w);
    endfunction

    function void predict_word(prs_in_t w);
      prs_out_t r;
      case (func_e'(w.func))
        FuncStep: run_tick(w);
        FuncSetError: begin
          if (w.set_value && cur_state != StError) switch_to(StError);
          fault_req = w.set_value;
          run_tick(w);
        end
        FuncSetUserLed: leds[LedUser] = w.set_value;
        FuncSetSysEn:   sys_en = w.set_value;
        FuncSetCtrlEn:  ctrl_en = w.set_value;
        FuncSetStop:    stop_req = w.set_value;
        default: ;
      endcase
      r.state_code      = cur_state;
      r.power_enable    = power_on;
      r.ready_led       = leds[LedReady];
      r.running_led     = leds[LedRunning];
      r.error_led       = leds[LedError];
      r.user_led        = leds[LedUser];
      r.system_enabled  = sys_en;
      r.control_enabled = ctrl_en;
      r.handshake_fault = hs_fault;
      pending_outputs.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR: result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_field(string name, logic [1:0] got, logic [1:0] want);
      if (got !== want) report($sformatf("%s is %0h, should be %0h", name, got, want));
    endtask

    task check_result(prs_out_t got);
      prs_out_t want;
      results_seen++;
      if (pending_outputs.size() == 0) begin
        report("result word arrived with nothing outstanding");
        return;
      end
      want = pending_outputs.pop_front();
      check_field("state_code", got.state_code, want.state_code);
      check_field("power_enable", got.power_enable, want.power_enable);
      check_field("ready_led", got.ready_led, want.ready_led);
      check_field("running_led", got.running_led, want.running_led);
      check_field("error_led", got.error_led, want.error_led);
      check_field("user_led", got.user_led, want.user_led);
      check_field("system_enabled", got.system_enabled, want.system_enabled);
      check_field("control_enabled", got.control_enabled, want.control_enabled);
      check_field("handshake_fault", got.handshake_fault, want.handshake_fault);
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  prs_in_if  in_if ();
  prs_out_if res_if ();
  prs_cfg_if cfg_if ();

  platform_run_supervisor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  supervisor_scoreboard sb;

  // Knobs shared between the stimulus and the result receiver. The stimulus turns gaps and
  // stalls on and off per phase, so one phase (p = 1) runs at full rate on both sides.
  bit tx_gaps_on;
  bit rx_stalls_on;
  bit long_hold_req;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic prs_in_t make_word(func_e f, bit v, bit bsys, bit bctrl, bit bstop,
                                        bit extn, logic [31:0] ms, logic [31:0] sec);
    prs_in_t w;
    w.func                  = f;
    w.set_value             = v;
    w.button_enable_system  = bsys;
    w.button_enable_control = bctrl;
    w.button_stop           = bstop;
    w.external_stop_n       = extn;
    w.ms_count              = ms;
    w.sec_count             = sec;
    return w;
  endfunction

  // Random word shaped to walk the machine through all its states: mostly ticks, the
  // system enable button mostly pressed, and the stop input mostly at its inactive level
  // for the current polarity. The rest are flag writes, error requests and unused codes.
  function automatic prs_in_t random_word(btn_mode_e mode);
    prs_in_t w;
    int r;
    bit stop_active;
    r = $urandom_range(0, 99);
    if (r < 55)      w.func = FuncStep;
    else if (r < 63) w.func = FuncSetError;
    else if (r < 70) w.func = FuncSetUserLed;
    else if (r < 77) w.func = FuncSetSysEn;
    else if (r < 84) w.func = FuncSetCtrlEn;
    else if (r < 90) w.func = FuncSetStop;
    else if (r < 97) w.func = 3'($urandom_range(0, 7));
    else             w.func = ($urandom_range(0, 1) != 0) ? FuncSpare6 : FuncSpare7;
    if (w.func == FuncSetError) w.set_value = ($urandom_range(0, 99) < 35);
    else                        w.set_value = $urandom_range(0, 1);
    w.button_enable_system  = ($urandom_range(0, 99) < 75);
    w.button_enable_control = $urandom_range(0, 1);
    stop_active             = ($urandom_range(0, 99) < 15);
    w.button_stop           = (mode == ModeStopLow) ? !stop_active : stop_active;
    w.external_stop_n       = ($urandom_range(0, 99) >= 10);
    case ($urandom_range(0, 3))
      0:       w.ms_count = $urandom_range(0, 399);
      1:       w.ms_count = 32'hFFFF_FFFF - $urandom_range(0, 300);
      default: w.ms_count = $urandom;
    endcase
    w.sec_count = $urandom;
    return w;
  endfunction

  // Called at a falling edge. Offers the word until the block takes it, then leaves valid
  // high unless a gap follows, so back-to-back words never drop valid in between.
  task automatic send_word(prs_in_t w);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Called at a falling edge with the input channel idle and nothing outstanding.
  task automatic program_regs(btn_mode_e mode, logic [CfgDataW-1:0] ext_word);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= prs_cfg_t'{RegButtonMode, mode};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.data  <= prs_cfg_t'{RegExtStopEn, ext_word};
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every predicted result has come back, plus the block's latency.
  task automatic wait_drained();
    while (sb.pending_outputs.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Transfers are sampled at the rising edge, before the block's own registers update.
  // A configuration write updates the shadow registers, an input word produces a prediction
  // and a result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.data);
      if (in_if.valid && in_if.ready) sb.predict_word(in_if.data);
      if (res_if.valid && res_if.ready) sb.check_result(res_if.data);
    end
  end

  // Result receiver. It counts its own stall cycles; a long hold requested by the stimulus
  // lets the block fill its input and result registers and push back on the input side.
  initial begin : result_receiver
    int stall_left;
    stall_left   = 0;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LongHold - 1;
        res_if.ready <= 1'b0;
      end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
        stall_left    = pick_gap();
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: the run is hung if no channel moves a word for IdleLimit cycles in a row.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("ERROR: no transfer on any channel for %0d cycles", IdleLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    prs_in_t   directed_words[$];
    btn_mode_e mode;
    int        p;

    sb            = new();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    tx_gaps_on    = 1'b1;
    rx_stalls_on  = 1'b1;
    long_hold_req = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, run with the reset configuration (stop button active high, external
    // stop off). It walks idle -> running -> control -> idle -> error -> idle, hits the blink
    // thresholds and uptime extremes, writes the user LED, enable and error flags both ways,
    // sets the stop flag, re-requests the error while already in error, and ends with an error
    // request before the last switch's entry action ran, which must raise the handshake fault.
    directed_words.push_back(make_word(FuncSpare7, 1, 1, 1, 1, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed_words.push_back(make_word(FuncStep, 0, 0, 0, 0, 1, 32'd0, 32'd1));
    directed_words.push_back(make_word(FuncStep, 0, 1, 0, 0, 1, 32'd0, 32'hFFFF_FFFE));
    directed_words.push_back(make_word(FuncStep, 1, 1, 1, 0, 1, 32'd0, 32'd3));
    directed_words.push_back(make_word(FuncStep, 0, 1, 1, 0, 1, 32'd101, 32'd0));
    directed_words.push_back(make_word(FuncStep, 0, 1, 1, 0, 1, 32'd100, 32'd0));
    directed_words.push_back(make_word(FuncSetUserLed, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncStep, 0, 1, 1, 1, 1, 32'hFFFF_FFFF, 32'd0));
    directed_words.push_back(make_word(FuncStep, 0, 1, 0, 1, 1, 32'd199, 32'd0));
    directed_words.push_back(make_word(FuncStep, 0, 1, 0, 0, 1, 32'd200, 32'd1));
    directed_words.push_back(make_word(FuncSetStop, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncStep, 0, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetError, 1, 0, 0, 0, 1, 32'd150, 32'd0));
    directed_words.push_back(make_word(FuncSetError, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetError, 0, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetSysEn, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetCtrlEn, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetCtrlEn, 0, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetSysEn, 0, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetUserLed, 0, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetStop, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncStep, 0, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSetError, 1, 0, 0, 0, 1, 32'd0, 32'd0));
    directed_words.push_back(make_word(FuncSpare6, 0, 0, 0, 0, 0, 32'd0, 32'd0));
    foreach (directed_words[i]) send_word(directed_words[i]);
    in_if.valid <= 1'b0;
    wait_drained();

    // Random phases. The first eight go through every button mode with the external stop
    // off and then on; the last ones pick a mode at random. The unused upper bit of the
    // external stop data is randomized. Gaps and stalls are switched per phase.
    for (p = 0; p < PhaseCount; p++) begin
      mode         = (p < 8) ? btn_mode_e'(p % 4) : btn_mode_e'($urandom_range(0, 3));
      tx_gaps_on   = (p % 3 != 1);
      rx_stalls_on = (p % 5 != 1);
      program_regs(mode, {1'($urandom_range(0, 1)), 1'((p / 4) % 2)});
      if (p == 3) begin
        // Back-pressure burst: hold results off for a long stretch while offering words
        // back to back, so the block fills up and stops taking input.
        long_hold_req = 1'b1;
        tx_gaps_on    = 1'b0;
        repeat (BurstWords) send_word(random_word(mode));
        tx_gaps_on    = 1'b1;
      end
      repeat (PhaseWords) send_word(random_word(mode));
      in_if.valid <= 1'b0;
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending_outputs.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
